FILE: design/at_socket_receive_parser_top_macros.svh
// Assertion macros for the socket receive parser top level.
// Depends on nothing; included by the top level only.
`ifndef AT_SOCKET_RECEIVE_PARSER_TOP_MACROS_SVH
`define AT_SOCKET_RECEIVE_PARSER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATSRP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atsrp check failed");

// The consequent must hold in the cycle after the antecedent.
`define ATSRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atsrp check failed");

`endif

FILE: design/atsrp_pkg.sv
// Package for the socket receive parser: item types, pattern tables and codes.
// Depends on nothing; used by at_socket_receive_parser_top.
package atsrp_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       response_start;
    } t_in_item;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       finished;
        logic [1:0] status;
        logic       header_seen;
    } t_out_item;

    localparam int unsigned MAX_COUNT_DIGITS_DEF = 4;
    localparam logic [7:0]  COUNT_SEPARATOR_DEF  = 8'd44;

    localparam int unsigned PAT_COUNT = 6;
    localparam int unsigned PAT_MAX   = 10;

    localparam logic [2:0] PAT_HEADER     = 3'd0;
    localparam logic [2:0] PAT_OK         = 3'd1;
    localparam logic [2:0] PAT_ERROR      = 3'd2;
    localparam logic [2:0] PAT_NO_CARRIER = 3'd3;
    localparam logic [2:0] PAT_NO_DIAL    = 3'd4;
    localparam logic [2:0] PAT_BUSY       = 3'd5;

    localparam logic [1:0] ST_PENDING = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_HANGUP  = 2'd3;

    localparam logic [2:0]  DIGITS_STOPPED = 3'd7;
    localparam logic [13:0] COUNT_LIMIT    = 14'd16383;
    localparam logic [3:0]  LINE_LIMIT     = 4'd15;
    localparam logic [5:0]  FLAGS_ALL      = 6'h3F;
    localparam logic [7:0]  CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0]  CHAR_SPACE     = 8'h20;
    localparam logic [7:0]  CHAR_ZERO      = 8'h30;
    localparam logic [7:0]  CHAR_NINE      = 8'h39;

    localparam logic [7:0] PAT_TEXT [PAT_COUNT][PAT_MAX] = '{
        '{"#", "S", "R", "E", "C", "V", 8'h0, 8'h0, 8'h0, 8'h0},
        '{"O", "K", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"E", "R", "R", "O", "R", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"N", "O", " ", "C", "A", "R", "R", "I", "E", "R"},
        '{"N", "O", " ", "D", "I", "A", "L", 8'h0, 8'h0, 8'h0},
        '{"B", "U", "S", "Y", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0}
    };

    localparam logic [3:0] PAT_LEN [PAT_COUNT] = '{4'd6, 4'd2, 4'd5, 4'd10, 4'd7, 4'd4};

    function automatic logic [7:0] pat_char(input int unsigned k, input logic [3:0] pos);
        logic [7:0] c;
        c = 8'h0;
        if (pos < 4'(PAT_MAX)) begin
            c = PAT_TEXT[k][pos];
        end
        return c;
    endfunction

endpackage

FILE: design/at_socket_receive_parser_top.sv
// Socket receive parser top level: byte-wise modem response parser.
// Depends on atsrp_pkg and at_socket_receive_parser_top_macros.svh.
//
// The input channel carries one item per received byte, with response_start
// set on the first byte after a command. The output channel carries one item
// for every input item: a payload byte, the end of the response with its
// status, or nothing of note, plus the header flag.
// Each item is parsed by the combinational logic in front of the result
// register, so a result appears in the cycle after its item is accepted,
// and one item per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the result register holds its item and the
// input side is stalled only while that full register cannot be emptied;
// an item is taken in the same cycle that the waiting result leaves.
// Synchronous reset clears the parser state to the start of a response and
// empties the result register.
module at_socket_receive_parser_top #(
    parameter int unsigned MAX_COUNT_DIGITS = atsrp_pkg::MAX_COUNT_DIGITS_DEF,
    parameter logic [7:0]  COUNT_SEPARATOR  = atsrp_pkg::COUNT_SEPARATOR_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  atsrp_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output atsrp_pkg::t_out_item  o_out_item
);
    import atsrp_pkg::*;

    `include "at_socket_receive_parser_top_macros.svh"

    logic [3:0]  r_line_pos, n_line_pos;
    logic [5:0]  r_flags, n_flags;
    logic [13:0] r_acc, n_acc;
    logic [2:0]  r_digits, n_digits;
    logic [13:0] r_remain, n_remain;
    logic        r_header, n_header;
    logic        r_done, n_done;
    logic [1:0]  r_fstat, n_fstat;
    logic        r_out_valid;
    t_out_item   r_out, n_out;
    logic        accept;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        logic [7:0]  b;
        logic [3:0]  line_pos;
        logic [5:0]  flags;
        logic [13:0] acc;
        logic [2:0]  digits;
        logic [13:0] remain;
        logic        found;
        logic [2:0]  hit;
        logic [17:0] prod;
        b        = i_in_item.rx_byte;
        line_pos = i_in_item.response_start ? 4'd0 : r_line_pos;
        flags    = i_in_item.response_start ? FLAGS_ALL : r_flags;
        acc      = i_in_item.response_start ? 14'd0 : r_acc;
        digits   = i_in_item.response_start ? 3'd0 : r_digits;
        remain   = i_in_item.response_start ? 14'd0 : r_remain;
        n_header = i_in_item.response_start ? 1'b0 : r_header;
        n_done   = i_in_item.response_start ? 1'b0 : r_done;
        n_fstat  = i_in_item.response_start ? ST_PENDING : r_fstat;
        n_line_pos = line_pos;
        n_flags    = flags;
        n_acc      = acc;
        n_digits   = digits;
        n_remain   = remain;
        found      = 1'b0;
        hit        = PAT_HEADER;
        prod       = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + 18'(b - CHAR_ZERO);
        n_out      = '0;

        if (n_done) begin
            n_out.status = n_fstat;
        end else if (remain != 14'd0) begin
            n_out.payload_valid = 1'b1;
            n_out.payload_byte  = b;
            n_remain            = remain - 14'd1;
            if (remain == 14'd1) begin
                n_line_pos = 4'd0;
                n_flags    = FLAGS_ALL;
                n_acc      = 14'd0;
                n_digits   = 3'd0;
            end
        end else if (b == CHAR_NEWLINE) begin
            for (int k = PAT_COUNT - 1; k >= 0; k--) begin
                if (flags[k] && line_pos >= PAT_LEN[k]) begin
                    found = 1'b1;
                    hit   = 3'(k);
                end
            end
            if (found) begin
                if (hit == PAT_HEADER) begin
                    n_header = 1'b1;
                    n_remain = acc;
                end else begin
                    n_done = 1'b1;
                    case (hit)
                        PAT_OK:    n_fstat = ST_OK;
                        PAT_ERROR: n_fstat = ST_ERROR;
                        default:   n_fstat = ST_HANGUP;
                    endcase
                    n_out.finished = 1'b1;
                    n_out.status   = n_fstat;
                end
            end
            n_line_pos = 4'd0;
            n_flags    = FLAGS_ALL;
            n_acc      = 14'd0;
            n_digits   = 3'd0;
        end else begin
            for (int k = 0; k < PAT_COUNT; k++) begin
                if (line_pos < PAT_LEN[k] && b != pat_char(k, line_pos)) begin
                    n_flags[k] = 1'b0;
                end
            end
            if (line_pos < LINE_LIMIT) begin
                n_line_pos = line_pos + 4'd1;
            end
            if (b == COUNT_SEPARATOR) begin
                n_acc    = 14'd0;
                n_digits = 3'd0;
            end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                if (digits != DIGITS_STOPPED && digits < 3'(MAX_COUNT_DIGITS)) begin
                    n_acc    = (prod > 18'(COUNT_LIMIT)) ? COUNT_LIMIT : prod[13:0];
                    n_digits = digits + 3'd1;
                end
            end else if (b == CHAR_SPACE && digits == 3'd0) begin
                n_digits = digits;
            end else begin
                n_digits = DIGITS_STOPPED;
            end
        end
        n_out.header_seen = n_header;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pos  <= 4'd0;
            r_flags     <= FLAGS_ALL;
            r_acc       <= 14'd0;
            r_digits    <= 3'd0;
            r_remain    <= 14'd0;
            r_header    <= 1'b0;
            r_done      <= 1'b0;
            r_fstat     <= ST_PENDING;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_line_pos  <= n_line_pos;
                r_flags     <= n_flags;
                r_acc       <= n_acc;
                r_digits    <= n_digits;
                r_remain    <= n_remain;
                r_header    <= n_header;
                r_done      <= n_done;
                r_fstat     <= n_fstat;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    `ATSRP_ASSERT_SAME(a_fin_has_status, i_clk, i_rst_n,
        r_out_valid && r_out.finished, r_out.status != ST_PENDING && !r_out.payload_valid)
    `ATSRP_ASSERT_SAME(a_payload_not_done, i_clk, i_rst_n,
        r_remain != 14'd0, !r_done)
    `ATSRP_ASSERT_NEXT(a_quiet_after_end, i_clk, i_rst_n,
        accept && r_done && !i_in_item.response_start,
        o_out_valid && !o_out_item.payload_valid && !o_out_item.finished)

endmodule

FILE: sim/atsrp_result_checker.sv
// Result checker for the socket receive parser: watches both channels, predicts
// each result from the accepted input items and compares it. Depends on atsrp_pkg.
`timescale 1ns / 1ps

module atsrp_result_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  atsrp_pkg::t_in_item  i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  atsrp_pkg::t_out_item i_out_item,
    output int                   o_fail_count,
    output int                   o_pending
);
    import atsrp_pkg::*;

    logic [3:0]  line_pos;
    logic [5:0]  match_flags;
    logic [13:0] count_acc;
    logic [2:0]  count_digits;
    logic [13:0] payload_left;
    logic        header_flag;
    logic        resp_done;
    logic [1:0]  resp_status;

    t_out_item   expected_q[$];

    task automatic start_line();
        line_pos = '0;
        match_flags = FLAGS_ALL;
        count_acc = '0;
        count_digits = '0;
    endtask

    task automatic clear_response();
        start_line();
        payload_left = '0;
        header_flag = 1'b0;
        resp_done = 1'b0;
        resp_status = ST_PENDING;
    endtask

    task automatic take_count_char(input logic [7:0] b);
        int acc_next;
        if (b == COUNT_SEPARATOR_DEF) begin
            count_acc = '0;
            count_digits = '0;
        end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            if (count_digits != DIGITS_STOPPED && count_digits < MAX_COUNT_DIGITS_DEF) begin
                acc_next = int'(count_acc) * 10 + int'(b - CHAR_ZERO);
                count_acc = (acc_next > int'(COUNT_LIMIT)) ? COUNT_LIMIT : 14'(acc_next);
                count_digits = count_digits + 3'd1;
            end
        end else if (!(b == CHAR_SPACE && count_digits == 3'd0)) begin
            count_digits = DIGITS_STOPPED;
        end
    endtask

    task automatic parse_byte(input t_in_item it, output t_out_item res);
        logic [7:0] b;
        logic       found;
        logic [2:0] hit;
        int         k;
        b = it.rx_byte;
        res = '0;
        found = 1'b0;
        hit = PAT_HEADER;
        if (it.response_start) begin
            clear_response();
        end
        if (resp_done) begin
            res.status = resp_status;
        end else if (payload_left != '0) begin
            res.payload_valid = 1'b1;
            res.payload_byte = b;
            payload_left = payload_left - 14'd1;
            if (payload_left == '0) begin
                start_line();
            end
        end else if (b == CHAR_NEWLINE) begin
            for (k = 0; k < PAT_COUNT; k++) begin
                if (!found && match_flags[k] && line_pos >= PAT_LEN[k]) begin
                    found = 1'b1;
                    hit = 3'(k);
                end
            end
            if (found && hit == PAT_HEADER) begin
                header_flag = 1'b1;
                payload_left = count_acc;
            end else if (found) begin
                resp_done = 1'b1;
                resp_status = (hit == PAT_OK) ? ST_OK : (hit == PAT_ERROR) ? ST_ERROR : ST_HANGUP;
                res.finished = 1'b1;
                res.status = resp_status;
            end
            start_line();
        end else begin
            for (k = 0; k < PAT_COUNT; k++) begin
                if (line_pos < PAT_LEN[k] && b != PAT_TEXT[k][line_pos]) begin
                    match_flags[k] = 1'b0;
                end
            end
            if (line_pos < LINE_LIMIT) begin
                line_pos = line_pos + 4'd1;
            end
            take_count_char(b);
        end
        res.header_seen = header_flag;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_out_item want;
        if (!i_rst_n) begin
            clear_response();
            expected_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result item arrived with no expectation waiting");
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("payload_valid", 8'(want.payload_valid),
                                8'(i_out_item.payload_valid));
                    check_field("payload_byte", want.payload_byte, i_out_item.payload_byte);
                    check_field("finished", 8'(want.finished), 8'(i_out_item.finished));
                    check_field("status", 8'(want.status), 8'(i_out_item.status));
                    check_field("header_seen", 8'(want.header_seen),
                                8'(i_out_item.header_seen));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                parse_byte(i_in_item, want);
                expected_q.push_back(want);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

FILE: sim/tb_top.sv
// Top of the socket receive parser testbench: clock, reset, byte stimulus,
// receiver stalls and the verdict. Depends on atsrp_pkg and atsrp_result_checker.
`timescale 1ns / 1ps

module tb_top;
    import atsrp_pkg::*;

    localparam int RANDOM_BYTES   = 1300;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    int        fail_count;
    int        pending;
    int        idle_cycles = 0;
    int        bytes_sent = 0;
    int        send_fast_left = 0;
    int        recv_fast_left = 0;
    logic      start_pending = 1'b0;
    logic      hold_req = 1'b0;

    always #5 clk = ~clk;

    at_socket_receive_parser_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    atsrp_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int pick_wait(inout int fast_left);
        if (fast_left > 0) begin
            fast_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            fast_left = $urandom_range(10, 40);
        end
        return $urandom_range(0, 14);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        t_in_item it;
        int       gap;
        logic     took;
        it.rx_byte = b;
        it.response_start = start_pending;
        start_pending = 1'b0;
        gap = pick_wait(send_fast_left);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do begin
            @(negedge clk);
            took = in_valid && !in_stall;
            @(posedge clk);
        end while (!took);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic send_line(input string s);
        send_text(s);
        send_byte(CHAR_NEWLINE);
    endtask

    function automatic string near_miss();
        case ($urandom_range(0, 6))
            0: return "O";
            1: return "ERRO";
            2: return "NO CARRIE";
            3: return "NO DIA";
            4: return "BUS";
            5: return "#SREC";
            default: return "";
        endcase
    endfunction

    task automatic send_noise_line(input string head);
        send_text(head);
        repeat ($urandom_range(0, 18)) send_byte(8'($urandom_range(11, 255)));
        send_byte(CHAR_NEWLINE);
    endtask

    task automatic send_response();
        string hdr;
        string pad;
        int    cnt;
        start_pending = 1'b1;
        repeat ($urandom_range(0, 2)) send_noise_line(near_miss());
        repeat ($urandom_range(0, 3)) begin
            cnt = ($urandom_range(0, 49) == 0) ? $urandom_range(200, 600) : $urandom_range(0, 24);
            pad = ($urandom_range(0, 1) == 1) ? " " : "";
            case ($urandom_range(0, 5))
                0: begin
                    hdr = "#SRECV: 1";
                    cnt = 0;
                end
                1: hdr = $sformatf("#SRECV: 1,7,%s%0d", pad, cnt);
                2: hdr = $sformatf("#SRECV: 1,%0dx9", cnt);
                3: hdr = $sformatf("#SRECV: 1,%04d%0d", cnt, $urandom_range(0, 9));
                default: hdr = $sformatf("#SRECV: 1,%s%0d", pad, cnt);
            endcase
            send_line(hdr);
            repeat (cnt) send_byte(8'($urandom));
        end
        case ($urandom_range(0, 7))
            0: send_line("OK");
            1: send_line("ERROR");
            2: send_line("NO CARRIER");
            3: send_line("NO DIAL");
            4: send_line("BUSY");
            5: send_noise_line("OK");
            6: send_text("OK");
            default: send_noise_line(near_miss());
        endcase
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do begin
            @(negedge clk);
        end while (pending != 0);
        @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial begin : receiver
        int   gap;
        logic took;
        wait (rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = pick_wait(recv_fast_left);
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do begin
                @(negedge clk);
                took = out_valid && !out_stall;
                @(posedge clk);
            end while (!took);
        end
    end

    initial begin : stimulus
        logic hold_done;
        logic drain_done;
        hold_done = 1'b0;
        drain_done = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A fifth count digit is ignored, so this header carries one payload byte.
        start_pending = 1'b1;
        send_line("#SRECV: 1,00012");
        send_byte(8'hFF);
        send_line("BUSY");
        send_byte(8'h00);
        start_pending = 1'b1;
        send_line("OK");
        start_pending = 1'b1;
        send_line("O");
        send_line("ERROR");
        start_pending = 1'b1;
        send_line("NO DIAL");
        start_pending = 1'b1;
        send_line("#SRECV");
        send_line("NO CARRIER");

        while (bytes_sent < RANDOM_BYTES) begin
            if (!hold_done && bytes_sent > 400) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && bytes_sent > 800) begin
                wait_drained();
                drain_done = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 12)) begin
                    start_pending = ($urandom_range(0, 7) == 0);
                    send_byte(8'($urandom));
                end
            end else begin
                send_response();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
